// ===== src/rvw_pkg.sv =====
// rvw_pkg: shared types and constants for the uniform grid ray voxel walker
// depends on nothing; used by the walker, its arithmetic unit and its checker
package rvw_pkg;

  localparam int CELLS_PER_AXIS_DEF = 16;
  localparam int FRAC_BITS_DEF      = 16;

  // largest distance, Q15.16 saturation point
  localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

  // reset value of the cell size registers (one unit)
  localparam logic [30:0] CELL_SIZE_RST = 31'h0001_0000;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_RESUME = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_LEFT      = 2'd1;
  localparam logic [1:0] ST_WRITTEN   = 2'd2;
  localparam logic [1:0] ST_NO_RAY    = 2'd3;

  localparam logic [2:0] REG_GRID_MIN_X  = 3'd0;
  localparam logic [2:0] REG_GRID_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_GRID_MIN_Z  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE_X = 3'd3;
  localparam logic [2:0] REG_CELL_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_CELL_SIZE_Z = 3'd5;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POS_GO,
    S_POS_WT,
    S_DLT_GO,
    S_DLT_WT,
    S_MUL_GO,
    S_MUL_WT,
    S_RD,
    S_CHK
  } state_t;

endpackage

// ===== src/rvw_ram.sv =====
// rvw_ram: generic single write port ram with one registered read port
// no dependencies
module rvw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rvw_alu.sv =====
// rvw_alu: bit-serial shared unit, restoring divide or shift-add multiply
// depends on rvw_pkg
module rvw_alu #(
  parameter int NW = 49,
  parameter int PW = 81
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rvw_pkg::alu_req_t   req,
  input  logic [NW-1:0]       a,
  input  logic [31:0]         b,
  output rvw_pkg::alu_rsp_t   rsp,
  output logic [PW-1:0]       res
);
  import rvw_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NW - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(31);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  alu_op_t         op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [NW-1:0]   a_r, a_nxt;
  logic [31:0]     b_r, b_nxt;

  logic [32:0] shifted;
  logic [32:0] diffv;
  logic        ge;
  logic        last;

  assign shifted = {rem_r, acc_r[NW-1]};
  assign diffv   = shifted - {1'b0, b_r};
  assign ge      = shifted >= {1'b0, b_r};
  assign last    = (op_r == ALU_DIV) ? (cnt_r == DIV_LAST) : (cnt_r == MUL_LAST);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (req.start) begin
      run_nxt = 1'b1;
      op_nxt  = req.op;
      cnt_nxt = '0;
      a_nxt   = a;
      b_nxt   = b;
      rem_nxt = '0;
      acc_nxt = (req.op == ALU_DIV) ? PW'(a) : '0;
    end else if (run_r) begin
      if (op_r == ALU_DIV) begin
        // one quotient bit a cycle
        rem_nxt = ge ? diffv[31:0] : shifted[31:0];
        acc_nxt = PW'({acc_r[NW-2:0], ge});
      end else begin
        // msb first over the multiplier
        acc_nxt = {acc_r[PW-2:0], 1'b0} + (b_r[31] ? PW'(a_r) : PW'(0));
        b_nxt   = {b_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign res        = acc_r;
  assign rsp.done   = done_r;
  assign rsp.rem_nz = |rem_r;

endmodule

// ===== src/uniform_grid_ray_voxel_walker.sv =====
// uniform_grid_ray_voxel_walker: 3d dda walk of a ray through a cubic voxel grid
// depends on rvw_pkg, rvw_ram (occupancy bitmap) and rvw_alu (shared divide/multiply)
//
// usage
//  - command channel: an item is taken at a clock edge with start high and busy low.
//    in_command selects an occupancy write, a ray start or a resume after a hit;
//    command three is dropped with no result
//  - result channel: each result sits on the out_ ports for one cycle with out_strobe
//    high; the receiver cannot hold it off, so nothing waits on the output side
//  - configuration: cfg_we writes register cfg_index with cfg_data at any edge;
//    only write while no command is in progress
//  - timing: a write answers on the next cycle and busy stays low. a start runs the
//    per-axis setup on the shared serial unit: per axis one divide for the entry
//    position, one more for the crossing step and a multiply (FRAC_BITS fraction
//    bits, Q16.16 by default); an axis with zero direction skips the second divide
//    and the multiply. the walk then reads and checks each visited cell in turn
//    (bitmap read is registered), at most 3*CELLS_PER_AXIS+2 cells, and the result
//    is registered from the last check. a resume walks only. one item at a time
//  - reset: synchronous active low; afterwards the bitmap is swept to zero, one entry
//    a cycle over all CELLS_PER_AXIS^3 entries (4096 by default) with busy high
module uniform_grid_ray_voxel_walker
  import rvw_pkg::*;
#(
  parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [11:0]        in_cell_address,
  input  logic               in_occupied,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [11:0]        out_found_cell,
  output logic [30:0]        out_t_enter,
  output logic [30:0]        out_t_exit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // geometry of the grid and of the fixed point words
  localparam int CW     = (CELLS_PER_AXIS > 1) ? $clog2(CELLS_PER_AXIS) : 1;
  localparam int NCELL  = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
  localparam int LW     = $clog2(NCELL);
  localparam int NW     = 33 + FRAC_BITS;   // dividend magnitude width
  localparam int PW     = NW + 32;          // product width
  localparam int PSW    = NW + 1;           // signed position width
  localparam int IW     = PSW - FRAC_BITS;  // signed whole-cell width
  localparam int ITW    = $clog2(3 * CELLS_PER_AXIS + 3);
  localparam logic [ITW-1:0] ITER_LAST = ITW'(3 * CELLS_PER_AXIS + 1);
  localparam logic [CW-1:0]  CELL_MAX  = CW'(CELLS_PER_AXIS - 1);

  // configuration registers
  logic [31:0] gmin_r [3];
  logic [30:0] csz_r  [3];

  // latched ray
  logic [31:0] org_r [3];
  logic [31:0] dir_r [3];

  // walk state
  state_t         state_r, state_nxt;
  logic [1:0]     axis_r;
  logic [CW-1:0]  cell_r [3];
  logic [30:0]    nx_r   [3];
  logic [30:0]    dl_r   [3];
  logic [2:0]     mv_r;
  logic [2:0]     neg_r;
  logic [30:0]    entry_r;
  logic           active_r;
  logic           lf_r;
  logic [ITW-1:0] it_r;
  logic [PSW-1:0] pos_r;
  logic [30:0]    delta_r;
  logic [LW-1:0]  clr_r;

  // result registers
  logic        out_strobe_r;
  logic [1:0]  out_status_r;
  logic [11:0] out_found_cell_r;
  logic [30:0] out_t_enter_r;
  logic [30:0] out_t_exit_r;

  // shared arithmetic unit
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic [NW-1:0] alu_a;
  logic [31:0]   alu_b;
  logic [PW-1:0] alu_res;

  // bitmap
  logic          ram_we;
  logic [LW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [LW-1:0] ram_raddr;
  logic          ram_rdata;

  logic accept;
  assign accept = start && !busy;

  // ---------------- per-axis setup arithmetic ----------------
  logic [31:0]    cur_org, cur_dir, cur_gmin;
  logic [30:0]    cs_eff;
  logic [32:0]    diff;
  logic           diff_neg;
  logic [32:0]    diff_mag;
  logic           dir_neg, dir_zero;
  logic [31:0]    dir_mag;
  logic [NW-1:0]  num_pos, num_cs;
  logic [PSW-1:0] q_ext, pos_new;
  logic [NW-1:0]  q_div;
  logic [30:0]    delta_sat;
  logic [PW-1:0]  prod_sh;
  logic [30:0]    next_sat;
  logic [IW-1:0]  idx_raw;
  logic [CW-1:0]  idx_c;
  logic [PSW:0]   pos_x, idx_scaled, one_x, frac_s;
  logic [NW-1:0]  frac;

  assign cur_org  = org_r[axis_r];
  assign cur_dir  = dir_r[axis_r];
  assign cur_gmin = gmin_r[axis_r];
  // a zero cell size counts as one lsb
  assign cs_eff   = (csz_r[axis_r] == 31'd0) ? 31'd1 : csz_r[axis_r];

  assign diff     = {cur_org[31], cur_org} - {cur_gmin[31], cur_gmin};
  assign diff_neg = diff[32];
  assign diff_mag = diff_neg ? (~diff + 33'd1) : diff;
  assign num_pos  = {diff_mag, {FRAC_BITS{1'b0}}};
  assign num_cs   = NW'({cs_eff, {FRAC_BITS{1'b0}}});

  assign dir_neg  = cur_dir[31];
  assign dir_zero = (cur_dir == 32'd0);
  assign dir_mag  = dir_neg ? (~cur_dir + 32'd1) : cur_dir;

  // floor division from magnitude quotient: negative and inexact rounds down
  assign q_div   = alu_res[NW-1:0];
  assign q_ext   = {1'b0, q_div};
  assign pos_new = diff_neg ? (~(q_ext + PSW'(alu_rsp.rem_nz)) + PSW'(1)) : q_ext;

  assign delta_sat = (q_div > NW'(T_MAX)) ? T_MAX : q_div[30:0];
  assign prod_sh   = alu_res >> FRAC_BITS;
  assign next_sat  = (prod_sh > PW'(T_MAX)) ? T_MAX : prod_sh[30:0];

  // entry cell, clamped into the grid
  assign idx_raw = pos_r[PSW-1:FRAC_BITS];
  always_comb begin
    if (idx_raw[IW-1]) begin
      idx_c = '0;
    end else if (idx_raw > IW'(CELLS_PER_AXIS - 1)) begin
      idx_c = CELL_MAX;
    end else begin
      idx_c = idx_raw[CW-1:0];
    end
  end

  // distance in cells to the first face, negative taken as zero
  assign pos_x      = {pos_r[PSW-1], pos_r};
  assign idx_scaled = {{(PSW+1-CW-FRAC_BITS){1'b0}}, idx_c, {FRAC_BITS{1'b0}}};
  assign one_x      = {{(PSW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  assign frac_s     = dir_neg ? (pos_x - idx_scaled) : (idx_scaled + one_x - pos_x);
  assign frac       = frac_s[PSW] ? '0 : frac_s[NW-1:0];

  // ---------------- walk step decision ----------------
  logic [1:0]    wa;
  logic [LW-1:0] lin;
  logic          wk_found, wk_bound, wk_leave;
  logic [31:0]   nx_sum;
  logic [30:0]   nx_step;
  logic [31:0]   lin32;

  // smallest crossing; ties go to z, then y
  always_comb begin
    if (nx_r[0] < nx_r[1]) begin
      wa = (nx_r[0] < nx_r[2]) ? 2'd0 : 2'd2;
    end else begin
      wa = (nx_r[1] < nx_r[2]) ? 2'd1 : 2'd2;
    end
  end

  assign lin = LW'(cell_r[0]) + LW'(CELLS_PER_AXIS) *
               (LW'(cell_r[1]) + LW'(CELLS_PER_AXIS) * LW'(cell_r[2]));
  assign lin32 = 32'(lin);

  // resume first leaves the cell it was reported in
  assign wk_found = !(lf_r && (it_r == '0)) && ram_rdata;
  assign wk_bound = neg_r[wa] ? (cell_r[wa] == '0) : (cell_r[wa] >= CELL_MAX);
  assign wk_leave = !mv_r[wa] || wk_bound || (it_r == ITER_LAST);

  assign nx_sum  = {1'b0, nx_r[wa]} + {1'b0, dl_r[wa]};
  assign nx_step = nx_sum[31] ? T_MAX : nx_sum[30:0];

  // write address of the command port
  logic [31:0] wa32;
  logic        waddr_ok;
  assign wa32     = 32'(in_cell_address);
  assign waddr_ok = wa32 < 32'(NCELL);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == LW'(NCELL - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_START) begin
            state_nxt = S_POS_GO;
          end else if (in_command == CMD_RESUME && active_r) begin
            state_nxt = S_RD;
          end
        end
      end
      S_POS_GO: state_nxt = S_POS_WT;
      S_POS_WT: begin
        if (alu_rsp.done) state_nxt = S_DLT_GO;
      end
      S_DLT_GO: begin
        if (!dir_zero) begin
          state_nxt = S_DLT_WT;
        end else begin
          state_nxt = (axis_r == 2'd2) ? S_RD : S_POS_GO;
        end
      end
      S_DLT_WT: begin
        if (alu_rsp.done) state_nxt = S_MUL_GO;
      end
      S_MUL_GO: state_nxt = S_MUL_WT;
      S_MUL_WT: begin
        if (alu_rsp.done) state_nxt = (axis_r == 2'd2) ? S_RD : S_POS_GO;
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = (wk_found || wk_leave) ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    busy      = 1'b1;
    alu_req   = '{start: 1'b0, op: ALU_DIV};
    alu_a     = num_pos;
    alu_b     = {1'b0, cs_eff};
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = 1'b0;
    ram_raddr = lin;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        busy      = 1'b0;
        ram_waddr = wa32[LW-1:0];
        ram_wdata = in_occupied;
        ram_we    = accept && (in_command == CMD_WRITE) && waddr_ok;
      end
      S_POS_GO: begin
        alu_req = '{start: 1'b1, op: ALU_DIV};
      end
      S_DLT_GO: begin
        alu_req = '{start: !dir_zero, op: ALU_DIV};
        alu_a   = num_cs;
        alu_b   = dir_mag;
      end
      S_MUL_GO: begin
        alu_req = '{start: 1'b1, op: ALU_MUL};
        alu_a   = frac;
        alu_b   = {1'b0, delta_r};
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      axis_r       <= '0;
      active_r     <= 1'b0;
      lf_r         <= 1'b0;
      it_r         <= '0;
      entry_r      <= '0;
      mv_r         <= '0;
      neg_r        <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        gmin_r[i] <= '0;
        csz_r[i]  <= CELL_SIZE_RST;
        cell_r[i] <= '0;
        nx_r[i]   <= '0;
        dl_r[i]   <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_MIN_X:  gmin_r[0] <= cfg_data;
          REG_GRID_MIN_Y:  gmin_r[1] <= cfg_data;
          REG_GRID_MIN_Z:  gmin_r[2] <= cfg_data;
          REG_CELL_SIZE_X: csz_r[0]  <= cfg_data[30:0];
          REG_CELL_SIZE_Y: csz_r[1]  <= cfg_data[30:0];
          REG_CELL_SIZE_Z: csz_r[2]  <= cfg_data[30:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + LW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            out_found_cell_r <= '0;
            out_t_enter_r    <= '0;
            out_t_exit_r     <= '0;
            unique case (in_command)
              CMD_WRITE: begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_WRITTEN;
              end
              CMD_START: begin
                org_r[0] <= in_origin_x;
                org_r[1] <= in_origin_y;
                org_r[2] <= in_origin_z;
                dir_r[0] <= in_dir_x;
                dir_r[1] <= in_dir_y;
                dir_r[2] <= in_dir_z;
                axis_r   <= '0;
              end
              CMD_RESUME: begin
                if (active_r) begin
                  lf_r <= 1'b1;
                  it_r <= '0;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_status_r <= ST_NO_RAY;
                end
              end
              default: ;
            endcase
          end
        end
        S_POS_WT: begin
          if (alu_rsp.done) pos_r <= pos_new;
        end
        S_DLT_GO: begin
          if (dir_zero) begin
            // still axis: never steps
            cell_r[axis_r] <= idx_c;
            nx_r[axis_r]   <= T_MAX;
            dl_r[axis_r]   <= T_MAX;
            mv_r[axis_r]   <= 1'b0;
            neg_r[axis_r]  <= 1'b0;
            axis_r         <= axis_r + 2'd1;
          end
        end
        S_DLT_WT: begin
          if (alu_rsp.done) begin
            delta_r        <= delta_sat;
            dl_r[axis_r]   <= delta_sat;
          end
        end
        S_MUL_GO: begin
          cell_r[axis_r] <= idx_c;
          mv_r[axis_r]   <= 1'b1;
          neg_r[axis_r]  <= dir_neg;
        end
        S_MUL_WT: begin
          if (alu_rsp.done) begin
            nx_r[axis_r] <= next_sat;
            axis_r       <= axis_r + 2'd1;
          end
        end
        S_RD: ;
        S_CHK: begin
          if (wk_found) begin
            out_strobe_r     <= 1'b1;
            out_status_r     <= ST_FOUND;
            out_found_cell_r <= lin32[11:0];
            out_t_enter_r    <= entry_r;
            out_t_exit_r     <= nx_r[wa];
          end else begin
            if (mv_r[wa]) entry_r <= nx_r[wa];
            if (mv_r[wa] && !wk_bound) begin
              cell_r[wa] <= neg_r[wa] ? (cell_r[wa] - CW'(1)) : (cell_r[wa] + CW'(1));
              nx_r[wa]   <= nx_step;
            end
            it_r <= it_r + ITW'(1);
            if (wk_leave) begin
              active_r         <= 1'b0;
              out_strobe_r     <= 1'b1;
              out_status_r     <= ST_LEFT;
              out_found_cell_r <= '0;
              out_t_enter_r    <= '0;
              out_t_exit_r     <= '0;
            end
          end
        end
        default: ;
      endcase

      // setup finished: walk from the entry cell
      if ((state_r == S_MUL_WT && alu_rsp.done && axis_r == 2'd2) ||
          (state_r == S_DLT_GO && dir_zero && axis_r == 2'd2)) begin
        entry_r  <= '0;
        active_r <= 1'b1;
        lf_r     <= 1'b0;
        it_r     <= '0;
      end
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_found_cell = out_found_cell_r;
  assign out_t_enter    = out_t_enter_r;
  assign out_t_exit     = out_t_exit_r;

  rvw_alu #(
    .NW (NW),
    .PW (PW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  rvw_ram #(
    .WIDTH (1),
    .DEPTH (NCELL)
  ) u_occ (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== src/rvw_chk.sv =====
// rvw_chk: port-level checks of the ray voxel walker, bound to the top level
// depends on rvw_pkg and uniform_grid_ray_voxel_walker
module rvw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_command,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [11:0] out_found_cell,
  input logic [30:0] out_t_enter,
  input logic [30:0] out_t_exit
);
  import rvw_pkg::*;

  // a write answers on the next cycle
  a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_WRITE) |=> (out_strobe && out_status == ST_WRITTEN))
    else $error("write item not answered next cycle");

  // a start raises busy while it runs the setup
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_START) |=> busy)
    else $error("start item did not raise busy");

  // the spare command gives no result
  a_none_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_NONE) |=> !out_strobe)
    else $error("spare command produced an item");

  // only a hit carries a cell and distances
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_FOUND) |->
      (out_found_cell == 12'd0 && out_t_enter == 31'd0 && out_t_exit == 31'd0))
    else $error("non-hit item carries payload");

  // the ray enters a cell before it leaves it
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FOUND) |-> (out_t_enter <= out_t_exit))
    else $error("entry distance beyond exit distance");

endmodule

bind uniform_grid_ray_voxel_walker rvw_chk u_rvw_chk (.*);
